### hw/rtl/slt_pkg.sv
package slt_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int OP_W        = 2;
  localparam int POS_W       = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  // Broadcast from the control side to every cell for one beat.
  typedef struct packed {
    logic             fire;     // beat accepted this cycle
    logic             insert;   // insert with room left
    logic             remove;   // remove operation
    logic             lookup;   // search or remove: compare enabled
    value_t           key;
    logic [CNT_W-1:0] lo;       // compare window start
    logic [CNT_W-1:0] hi;       // compare window end (exclusive, clipped)
    logic [CNT_W-1:0] wr_pos;   // append slot (current count)
  } cell_ctrl_t;

endpackage

### hw/rtl/slt_if.sv
interface slt_req_if;
  logic                           valid;
  logic                           ready;
  logic [slt_pkg::OP_W-1:0]       operation;
  logic signed [31:0]             key_value;
  logic [4:0]                     range_start;
  logic [4:0]                     range_end;

  modport source (output valid, operation, key_value, range_start, range_end, input ready);
  modport sink   (input valid, operation, key_value, range_start, range_end, output ready);
endinterface

interface slt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           success;
  logic signed [4:0]              found_position;
  logic [4:0]                     entry_count;
  logic                           is_full;
  logic                           is_empty;

  modport source (output valid, success, found_position, entry_count, is_full, is_empty,
                  input ready);
  modport sink   (input valid, success, found_position, entry_count, is_full, is_empty,
                  output ready);
endinterface

### hw/rtl/slt_cell.sv
// One table slot: compares against the key, tracks the first-match chain
// and shifts in its upper neighbor's value on a remove at or below it.
module slt_cell (
  input  logic                       clk,
  input  slt_pkg::cell_ctrl_t        ctrl,
  input  logic [slt_pkg::IDX_W-1:0]  index,
  input  logic                       seen_in,
  input  slt_pkg::value_t            next_val,
  output logic                       seen_out,
  output logic                       first,
  output slt_pkg::value_t            val
);

  logic [slt_pkg::CNT_W-1:0] pos;
  logic                      in_win;
  logic                      hit;

  assign pos      = slt_pkg::CNT_W'(index);
  assign in_win   = (pos >= ctrl.lo) && (pos < ctrl.hi);
  assign hit      = ctrl.lookup && in_win && (val == ctrl.key);
  assign first    = hit && !seen_in;
  assign seen_out = seen_in || hit;

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      if (ctrl.remove && seen_out) begin
        val <= next_val;
      end else if (ctrl.insert && (pos == ctrl.wr_pos)) begin
        val <= ctrl.key;
      end
    end
  end

endmodule

### hw/rtl/sequential_list_table_unit.sv
// Packed list table of slt_pkg::DEPTH signed values held in a row of cells,
// one value per cell, plus an occupancy count. Each request beat carries an
// operation: insert appends key_value at the end (fails when full), search
// returns the first position in [range_start, min(range_end, count)) that
// holds key_value, remove deletes the first match anywhere in the table and
// every later cell takes its upper neighbor's value, clear empties the
// table. Exactly one response beat follows each request, carrying success,
// the match position (-1 when none, and always -1 for insert and clear),
// the count after the operation and the full/empty flags. Every operation
// completes in a single pass: all cells compare in parallel and the first-match
// flag ripples along the row in the same cycle, so a request is taken every
// cycle while the response register is empty or being drained. The response
// is registered: valid rises in the cycle after the request beat is taken.
// No request is taken while rst is high. Cell contents have no reset; only
// positions below the count are ever compared.
module sequential_list_table_unit (
  input  logic       clk,
  input  logic       rst,
  slt_req_if.sink    req,
  slt_rsp_if.source  rsp
);

  localparam int N = slt_pkg::DEPTH;

  // Control and count
  logic [slt_pkg::CNT_W-1:0] count;
  logic [slt_pkg::CNT_W-1:0] count_next;
  logic                      fire;
  logic                      full_now;
  logic [slt_pkg::CNT_W-1:0] end_clip;
  slt_pkg::cell_ctrl_t       ctrl;

  // Cell row
  logic                      seen [N+1];
  logic [N-1:0]              first_vec;
  slt_pkg::value_t           vals [N];

  // Result formation
  logic [slt_pkg::IDX_W-1:0] hit_idx;
  logic                      any_hit;
  logic                      ok;
  logic signed [slt_pkg::POS_W-1:0] pos_res;

  assign req.ready = !rst && (!rsp.valid || rsp.ready);
  assign fire      = req.valid && req.ready;
  assign full_now  = (count == slt_pkg::CNT_W'(N));

  // Search end is clipped to the current count.
  assign end_clip = (slt_pkg::CNT_W'(req.range_end) < count) ?
                    slt_pkg::CNT_W'(req.range_end) : count;

  always_comb begin
    ctrl        = '0;
    ctrl.fire   = fire;
    ctrl.key    = slt_pkg::value_t'(req.key_value);
    ctrl.wr_pos = count;
    ctrl.insert = (req.operation == slt_pkg::OP_INSERT) && !full_now;
    ctrl.remove = (req.operation == slt_pkg::OP_REMOVE);
    case (req.operation)
      slt_pkg::OP_SEARCH: begin
        ctrl.lookup = 1'b1;
        ctrl.lo     = slt_pkg::CNT_W'(req.range_start);
        ctrl.hi     = end_clip;
      end
      slt_pkg::OP_REMOVE: begin
        ctrl.lookup = 1'b1;
        ctrl.lo     = '0;
        ctrl.hi     = count;
      end
      default: begin
        ctrl.lookup = 1'b0;
      end
    endcase
  end

  // Row of cells; the first-match flag runs from position 0 upward and the
  // shift data runs downward. The top cell just keeps its own value.
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    slt_pkg::value_t upper;
    if (i == N - 1) begin : g_top
      assign upper = vals[i];
    end else begin : g_mid
      assign upper = vals[i+1];
    end
    slt_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .index    (slt_pkg::IDX_W'(i)),
      .seen_in  (seen[i]),
      .next_val (upper),
      .seen_out (seen[i+1]),
      .first    (first_vec[i]),
      .val      (vals[i])
    );
  end

  assign any_hit = seen[N];

  // One-hot to index
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (first_vec[i]) begin
        hit_idx = hit_idx | slt_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    count_next = count;
    ok         = 1'b0;
    case (req.operation)
      slt_pkg::OP_INSERT: begin
        ok = !full_now;
        if (!full_now) begin
          count_next = count + 1'b1;
        end
      end
      slt_pkg::OP_SEARCH: begin
        ok = any_hit;
      end
      slt_pkg::OP_REMOVE: begin
        ok = any_hit;
        if (any_hit) begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        ok         = 1'b1;
        count_next = '0;
      end
    endcase
  end

  // Insert and clear never report a position.
  assign pos_res = (ctrl.lookup && any_hit) ? slt_pkg::POS_W'(hit_idx) : '1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (fire) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Response payload, loaded with each accepted beat
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.success        <= ok;
      rsp.found_position <= pos_res;
      rsp.entry_count    <= 5'(count_next);
      rsp.is_full        <= (count_next == slt_pkg::CNT_W'(N));
      rsp.is_empty       <= (count_next == '0);
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= slt_pkg::CNT_W'(N))
    else $error("count exceeds table depth");

  a_first_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(first_vec))
    else $error("more than one first match");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    fire && req.operation == slt_pkg::OP_CLEAR |=> count == '0 && rsp.is_empty)
    else $error("clear did not empty the table");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    fire && req.operation == slt_pkg::OP_REMOVE && any_hit
    |=> count == $past(count) - 1'b1 && rsp.success)
    else $error("remove hit did not decrement count");
`endif

endmodule
